@@ rtl/ohlc_pkg.sv @@
// Shared constants, command and status types for the OHLC bar aggregator.
`timescale 1ns / 1ps

package ohlc_pkg;

    // Fixed field widths.
    localparam int TIME_W   = 18;
    localparam int DATE_W   = 27;
    localparam int MIN_W    = 12;
    localparam int PERIOD_W = 11;

    // Defaults for the top-level width parameters.
    localparam int PRICE_WIDTH_DEF  = 32;
    localparam int VOLUME_WIDTH_DEF = 48;

    // HHMMSS / 100 by reciprocal multiplication, exact for every 18-bit input.
    localparam int                     FOLD_MULT_W = 19;
    localparam logic [FOLD_MULT_W-1:0] FOLD_MULT   = 19'd335545;
    localparam int                     FOLD_SHIFT  = 25;
    localparam int                     FOLD_PROD_W = TIME_W + FOLD_MULT_W;

    // HHMM / 100 by reciprocal multiplication, exact for every 12-bit input.
    localparam int                     HUND_MULT_W = 11;
    localparam logic [HUND_MULT_W-1:0] HUND_MULT   = 11'd1311;
    localparam int                     HUND_SHIFT  = 17;
    localparam int                     HUND_PROD_W = MIN_W + HUND_MULT_W;
    localparam int                     HUND_Q_W    = HUND_PROD_W - HUND_SHIFT;

    // Minute-of-hour remainder unit: one quotient bit per cycle.
    localparam int REM_W      = 7;
    localparam int DIV_STEPS  = REM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Session times in HHMM.
    localparam logic [MIN_W-1:0] T_0925 = 12'd925;
    localparam logic [MIN_W-1:0] T_0930 = 12'd930;
    localparam logic [MIN_W-1:0] T_1030 = 12'd1030;
    localparam logic [MIN_W-1:0] T_1129 = 12'd1129;
    localparam logic [MIN_W-1:0] T_1130 = 12'd1130;
    localparam logic [MIN_W-1:0] T_1300 = 12'd1300;
    localparam logic [MIN_W-1:0] T_1459 = 12'd1459;
    localparam logic [MIN_W-1:0] T_1500 = 12'd1500;

    // Period codes.
    localparam logic [PERIOD_W-1:0] PERIOD_NONE   = 11'd0;
    localparam logic [PERIOD_W-1:0] PERIOD_ONE    = 11'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_HOURLY = 11'd60;
    localparam logic [PERIOD_W-1:0] PERIOD_DAILY  = 11'd1440;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_ONE;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic fold;
        logic clamp;
        logic split;
        logic rem;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic out_valid;
    } t_dp_status;

endpackage

@@ rtl/ohlc_ctrl.sv @@
// Sequencing state machine for the OHLC bar aggregator.
`timescale 1ns / 1ps

module ohlc_ctrl
    import ohlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_CLAMP,
        S_SPLIT,
        S_REM,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic                 r_in_ready;
    logic                 n_in_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_in_ready = r_in_ready;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_in_ready = 1'b0;
                    n_state    = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_COMMIT: begin
                // Hold here while the previous result has not been taken.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_in_ready   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_in_ready = 1'b1;
                n_state    = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

`ifndef SYNTH
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside the idle state");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_commit_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while the output register is still occupied");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> i_sts.out_valid)
        else $error("commit did not present a result");
`endif

endmodule

@@ rtl/ohlc_dp.sv @@
// Datapath of the OHLC bar aggregator: time folding, bucketing and bar state.
`timescale 1ns / 1ps

module ohlc_dp
    import ohlc_pkg::*;
#(
    parameter int PRICE_WIDTH  = PRICE_WIDTH_DEF,
    parameter int VOLUME_WIDTH = VOLUME_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_sts,
    input  logic                    i_cfg_valid,
    input  logic [PERIOD_W-1:0]     i_cfg_data,
    input  logic [TIME_W-1:0]       i_update_time,
    input  logic [DATE_W-1:0]       i_trading_day,
    input  logic [PRICE_WIDTH-1:0]  i_last_price,
    input  logic [VOLUME_WIDTH-2:0] i_total_volume,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [DATE_W-1:0]       o_bar_date,
    output logic [MIN_W-1:0]        o_bar_time,
    output logic [PRICE_WIDTH-1:0]  o_open_price,
    output logic [PRICE_WIDTH-1:0]  o_high_price,
    output logic [PRICE_WIDTH-1:0]  o_low_price,
    output logic [PRICE_WIDTH-1:0]  o_close_price,
    output logic [VOLUME_WIDTH-1:0] o_bar_volume,
    output logic                    o_new_bar
);

    // Captured tick.
    logic [TIME_W-1:0]       r_time;
    logic [DATE_W-1:0]       r_day;
    logic [PRICE_WIDTH-1:0]  r_price;
    logic [VOLUME_WIDTH-2:0] r_total;

    // Time folding and bucketing.
    logic [MIN_W-1:0]        r_min;
    logic [MIN_W-1:0]        r_t;
    logic [HUND_Q_W-1:0]     r_hh;
    logic [REM_W-1:0]        r_divd;
    logic [REM_W-1:0]        r_part;

    // Configuration and bar state.
    logic [PERIOD_W-1:0]     r_period;
    logic                    r_bar_valid;
    logic                    r_out_valid;
    logic [VOLUME_WIDTH-1:0] r_prev_total;
    logic [DATE_W-1:0]       r_cur_date;
    logic [MIN_W-1:0]        r_cur_time;
    logic [PRICE_WIDTH-1:0]  r_cur_open;
    logic [PRICE_WIDTH-1:0]  r_cur_high;
    logic [PRICE_WIDTH-1:0]  r_cur_low;
    logic [PRICE_WIDTH-1:0]  r_cur_close;
    logic [VOLUME_WIDTH-1:0] r_cur_volume;
    logic                    r_new_bar;

    logic [FOLD_PROD_W-1:0]  w_prod1;
    logic [MIN_W-1:0]        w_clamped;
    logic [HUND_PROD_W-1:0]  w_prod2;
    logic [MIN_W-1:0]        w_hh_x100;
    logic [MIN_W-1:0]        w_rem_full;
    logic [REM_W:0]          w_trial;
    logic [PERIOD_W-1:0]     w_trial_ext;
    logic [PERIOD_W-1:0]     w_diff;
    logic [MIN_W-1:0]        w_bucket;
    logic                    w_opened;
    logic [VOLUME_WIDTH-1:0] w_delta;

    assign w_prod1 = FOLD_PROD_W'(r_time) * FOLD_PROD_W'(FOLD_MULT);

    // Session clamp: pre-open minute, lunch gap and after close.
    always_comb begin
        w_clamped = r_min;
        if (w_clamped == T_0925) begin
            w_clamped = T_0930;
        end
        if (w_clamped >= T_1130 && w_clamped < T_1300) begin
            w_clamped = T_1129;
        end
        if (w_clamped >= T_1500) begin
            w_clamped = T_1459;
        end
    end

    assign w_prod2    = HUND_PROD_W'(r_t) * HUND_PROD_W'(HUND_MULT);
    assign w_hh_x100  = MIN_W'({r_hh, 6'b0}) + MIN_W'({r_hh, 5'b0}) + MIN_W'({r_hh, 2'b0});
    assign w_rem_full = r_t - w_hh_x100;

    // Restoring remainder step: minute-of-hour modulo the period.
    assign w_trial     = {r_part, r_divd[REM_W-1]};
    assign w_trial_ext = PERIOD_W'(w_trial);
    assign w_diff      = w_trial_ext - r_period;

    always_comb begin
        if (r_period == PERIOD_NONE || r_period == PERIOD_ONE) begin
            w_bucket = r_t;
        end else if (r_period >= PERIOD_DAILY) begin
            w_bucket = '0;
        end else if (r_period == PERIOD_HOURLY && r_t >= T_0930 && r_t < T_1030) begin
            w_bucket = T_0930;
        end else if (r_period == PERIOD_HOURLY && r_t >= T_1030 && r_t < T_1130) begin
            w_bucket = T_1030;
        end else begin
            w_bucket = r_t - MIN_W'(r_part);
        end
    end

    assign w_opened = !r_bar_valid || (r_cur_time != w_bucket) || (r_cur_date != r_day);
    assign w_delta  = VOLUME_WIDTH'(r_total) - r_prev_total;

    // Control state and the reset-valued previous volume.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= PERIOD_RESET;
            r_bar_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_total <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_bar_valid  <= 1'b1;
                r_out_valid  <= 1'b1;
                r_prev_total <= VOLUME_WIDTH'(r_total);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time  <= i_update_time;
            r_day   <= i_trading_day;
            r_price <= i_last_price;
            r_total <= i_total_volume;
        end
        if (i_cmd.fold) begin
            r_min <= w_prod1[FOLD_PROD_W-1:FOLD_SHIFT];
        end
        if (i_cmd.clamp) begin
            r_t <= w_clamped;
        end
        if (i_cmd.split) begin
            r_hh <= w_prod2[HUND_PROD_W-1:HUND_SHIFT];
        end
        if (i_cmd.rem) begin
            r_divd <= w_rem_full[REM_W-1:0];
            r_part <= '0;
        end
        if (i_cmd.div_step) begin
            r_divd <= {r_divd[REM_W-2:0], 1'b0};
            if (w_trial_ext >= r_period) begin
                r_part <= w_diff[REM_W-1:0];
            end else begin
                r_part <= w_trial[REM_W-1:0];
            end
        end
        if (i_cmd.commit) begin
            r_new_bar   <= w_opened;
            r_cur_close <= r_price;
            if (w_opened) begin
                r_cur_date   <= r_day;
                r_cur_time   <= w_bucket;
                r_cur_open   <= r_price;
                r_cur_high   <= r_price;
                r_cur_low    <= r_price;
                r_cur_volume <= w_delta;
            end else begin
                if (r_price > r_cur_high) begin
                    r_cur_high <= r_price;
                end
                if (r_price < r_cur_low) begin
                    r_cur_low <= r_price;
                end
                r_cur_volume <= r_cur_volume + w_delta;
            end
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.out_valid = r_out_valid;

    assign o_out_valid   = r_out_valid;
    assign o_bar_date    = r_cur_date;
    assign o_bar_time    = r_cur_time;
    assign o_open_price  = r_cur_open;
    assign o_high_price  = r_cur_high;
    assign o_low_price   = r_cur_low;
    assign o_close_price = r_cur_close;
    assign o_bar_volume  = r_cur_volume;
    assign o_new_bar     = r_new_bar;

`ifndef SYNTH
    a_new_bar_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_new_bar) |->
            (r_cur_open == r_cur_high) && (r_cur_open == r_cur_low) &&
            (r_cur_open == r_cur_close))
        else $error("freshly opened bar is not flat");

    a_close_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bar_valid |-> (r_cur_low <= r_cur_close) && (r_cur_close <= r_cur_high))
        else $error("close price outside the bar's low to high range");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_bar_valid && r_out_valid))
        else $error("commit did not leave an open bar on the output");
`endif

endmodule

@@ rtl/ohlc_bar_aggregator_top.sv @@
// Top level of the OHLC bar aggregator: a tick stream in, a current-bar stream out.
// A result is offered once its tick is committed; the commit waits while the previous
// result is still waiting at the output. Ticks are taken one at a time: the next is
// accepted only after the last one is committed. The seven-step remainder unit
// reduces the minute of the hour modulo the period, one bit per cycle.
// Reset: synchronous, active low; it clears the sequencer, the open-bar flag and the
// previous cumulative volume and sets the period register to one minute.
`timescale 1ns / 1ps

module ohlc_bar_aggregator_top
    import ohlc_pkg::*;
#(
    parameter int PRICE_WIDTH  = PRICE_WIDTH_DEF,
    parameter int VOLUME_WIDTH = VOLUME_WIDTH_DEF,
    // Stream widths follow from the field widths, rounded up to whole bytes.
    localparam int IN_BITS     = TIME_W + DATE_W + PRICE_WIDTH + VOLUME_WIDTH - 1,
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = DATE_W + MIN_W + 4 * PRICE_WIDTH + VOLUME_WIDTH,
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Tick input channel.
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // tdata, lowest bit up: update_time, trading_day, last_price, total_volume, zero pad.
    input  logic [IN_W-1:0]     i_s_axis_tdata,

    // Bar output channel.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // tdata, lowest bit up: bar_date, bar_time, open_price, high_price, low_price,
    // close_price, bar_volume, zero pad.
    output logic [OUT_W-1:0]    o_m_axis_tdata,
    // tuser: new_bar.
    output logic                o_m_axis_tuser,

    // Period register write channel.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [PERIOD_W-1:0] i_cfg_data
);

    // Bit offsets of the input fields.
    localparam int IN_DAY_LSB   = TIME_W;
    localparam int IN_PRICE_LSB = IN_DAY_LSB + DATE_W;
    localparam int IN_TOTAL_LSB = IN_PRICE_LSB + PRICE_WIDTH;

    // Bit offsets of the output fields.
    localparam int OUT_TIME_LSB  = DATE_W;
    localparam int OUT_OPEN_LSB  = OUT_TIME_LSB + MIN_W;
    localparam int OUT_HIGH_LSB  = OUT_OPEN_LSB + PRICE_WIDTH;
    localparam int OUT_LOW_LSB   = OUT_HIGH_LSB + PRICE_WIDTH;
    localparam int OUT_CLOSE_LSB = OUT_LOW_LSB + PRICE_WIDTH;
    localparam int OUT_VOL_LSB   = OUT_CLOSE_LSB + PRICE_WIDTH;

    t_dp_cmd                 w_cmd;
    t_dp_status              w_sts;

    logic [DATE_W-1:0]       w_bar_date;
    logic [MIN_W-1:0]        w_bar_time;
    logic [PRICE_WIDTH-1:0]  w_open_price;
    logic [PRICE_WIDTH-1:0]  w_high_price;
    logic [PRICE_WIDTH-1:0]  w_low_price;
    logic [PRICE_WIDTH-1:0]  w_close_price;
    logic [VOLUME_WIDTH-1:0] w_bar_volume;

    // The period register is a plain flop in the datapath; a write transaction is
    // always taken. The user must write only with no tick in flight; nothing enforces it.
    assign o_cfg_ready = 1'b1;

    // The controller walks one tick through the stages in turn: capture, divide
    // HHMMSS by 100, clamp to the session, split off the hour, form the minute of
    // the hour, reduce it modulo the period one bit per cycle, then commit the bar.
    // The commit waits only if the previous result has not been taken yet, so the
    // next tick can be accepted and worked on while a result sits at the output.
    ohlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // The bar state registers double as the output register: they change only at
    // a commit, and a commit happens only when the output is free.
    ohlc_dp #(
        .PRICE_WIDTH  (PRICE_WIDTH),
        .VOLUME_WIDTH (VOLUME_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_update_time  (i_s_axis_tdata[TIME_W-1:0]),
        .i_trading_day  (i_s_axis_tdata[IN_DAY_LSB +: DATE_W]),
        .i_last_price   (i_s_axis_tdata[IN_PRICE_LSB +: PRICE_WIDTH]),
        .i_total_volume (i_s_axis_tdata[IN_TOTAL_LSB +: VOLUME_WIDTH-1]),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_bar_date     (w_bar_date),
        .o_bar_time     (w_bar_time),
        .o_open_price   (w_open_price),
        .o_high_price   (w_high_price),
        .o_low_price    (w_low_price),
        .o_close_price  (w_close_price),
        .o_bar_volume   (w_bar_volume),
        .o_new_bar      (o_m_axis_tuser)
    );

    // Pack the result, first field in the lowest bits, pad bits held at zero.
    always_comb begin
        o_m_axis_tdata                                  = '0;
        o_m_axis_tdata[DATE_W-1:0]                      = w_bar_date;
        o_m_axis_tdata[OUT_TIME_LSB +: MIN_W]           = w_bar_time;
        o_m_axis_tdata[OUT_OPEN_LSB +: PRICE_WIDTH]     = w_open_price;
        o_m_axis_tdata[OUT_HIGH_LSB +: PRICE_WIDTH]     = w_high_price;
        o_m_axis_tdata[OUT_LOW_LSB +: PRICE_WIDTH]      = w_low_price;
        o_m_axis_tdata[OUT_CLOSE_LSB +: PRICE_WIDTH]    = w_close_price;
        o_m_axis_tdata[OUT_VOL_LSB +: VOLUME_WIDTH]     = w_bar_volume;
    end

endmodule
